// File: src/rncm_pkg.sv
`default_nettype none
package rncm_pkg;

  // default depth of the queue between the front and back parts
  localparam int unsigned QueueDepth = 4;

  // field and datapath widths
  localparam int unsigned ValW    = 16;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned AccW    = 40;
  localparam int unsigned ResW    = 24;
  localparam int unsigned SqW     = 47;
  localparam int unsigned NormW   = 48;
  localparam int unsigned StatusW = 3;

  // configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 64;
  localparam logic [AddrW-1:0] RegTolerance = 3'd0;

  // status codes
  localparam logic [StatusW-1:0] StIndeterminate = 3'd0;
  localparam logic [StatusW-1:0] StConverging    = 3'd1;
  localparam logic [StatusW-1:0] StDiverging     = 3'd2;
  localparam logic [StatusW-1:0] StConverged     = 3'd3;
  localparam logic [StatusW-1:0] StDiverged      = 3'd4;

  // one classified beat as it waits in the queue
  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic signed [ValW-1:0]  rhs;
    logic                    close;
    logic                    mend;
  } rncm_item_t;

endpackage
`default_nettype wire

// File: src/rncm_front.sv
`default_nettype none
module rncm_front
  import rncm_pkg::*;
(
  input  wire logic                   push,
  output      logic                   full,
  input  wire logic signed [ValW-1:0] matrix_value_i,
  input  wire logic signed [ValW-1:0] guess_value_i,
  input  wire logic signed [ValW-1:0] rhs_value_i,
  input  wire logic                   row_end_i,
  input  wire logic                   matrix_end_i,
  input  wire logic                   q_full_i,
  output      logic                   q_wr_o,
  output      rncm_item_t             q_item_o
);

  logic signed [ProdW-1:0] prod;

  // exact q8.24 product of matrix and guess element
  assign prod = matrix_value_i * guess_value_i;

  // classify the beat: matrix end also closes the row
  always_comb begin
    q_item_o.prod  = prod;
    q_item_o.rhs   = rhs_value_i;
    q_item_o.close = row_end_i | matrix_end_i;
    q_item_o.mend  = matrix_end_i;
  end

  assign full   = q_full_i;
  assign q_wr_o = push & ~q_full_i;

endmodule
`default_nettype wire

// File: src/rncm_fifo.sv
`default_nettype none
module rncm_fifo
  import rncm_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_i,
  input  wire rncm_item_t wr_item_i,
  output      logic       full_o,
  input  wire logic       rd_i,
  output      rncm_item_t rd_item_o,
  output      logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  rncm_item_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_item_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

// File: src/rncm_back.sv
`default_nettype none
module rncm_back
  import rncm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rncm_item_t          q_item_i,
  input  wire logic                q_empty_i,
  output      logic                q_rd_o,
  input  wire logic [NormW-1:0]    tolerance_i,
  output      logic                empty,
  input  wire logic                pop,
  output      logic [StatusW-1:0]  status_o,
  output      logic [NormW-1:0]    norm_squared_o
);

  localparam logic [2:0] SAcc  = 3'd0;
  localparam logic [2:0] SRes  = 3'd1;
  localparam logic [2:0] SSq   = 3'd2;
  localparam logic [2:0] SNorm = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [ResW-1:0] ResMax = {1'b0, {(ResW-1){1'b1}}};
  localparam logic signed [ResW-1:0] ResMin = {1'b1, {(ResW-1){1'b0}}};

  logic [2:0]               state_q, state_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic [NormW-1:0]         norm_q, norm_d;
  logic [NormW-1:0]         prev_q, prev_d;
  logic                     ovf_q, ovf_d;
  logic                     valid_q, valid_d;
  logic signed [ValW-1:0]   rhs_q, rhs_d;
  logic                     mend_q, mend_d;
  logic signed [ResW-1:0]   res_q, res_d;
  logic [SqW-1:0]           sq_q, sq_d;
  logic [StatusW-1:0]       status_q, status_d;
  logic [NormW-1:0]         out_norm_q, out_norm_d;

  logic signed [AccW:0]     acc_sum;
  logic signed [AccW+1:0]   resid;
  logic signed [AccW+1:0]   resid_rnd;
  logic signed [AccW-11:0]  resid_q12;
  logic signed [2*ResW-1:0] res_sq;
  logic [NormW:0]           norm_sum;
  logic                     slot_free;

  // datapath terms
  assign acc_sum   = (AccW+1)'(acc_q) + (AccW+1)'(q_item_i.prod);
  assign resid     = (AccW+2)'(acc_q) - ((AccW+2)'(rhs_q) <<< 12);
  assign resid_rnd = resid + (AccW+2)'(2048);
  assign resid_q12 = resid_rnd[AccW+1:12];
  assign res_sq    = res_q * res_q;
  assign norm_sum  = {1'b0, norm_q} + (NormW+1)'(sq_q);
  assign slot_free = ~valid_q | pop;

  assign empty          = ~valid_q;
  assign status_o       = status_q;
  assign norm_squared_o = out_norm_q;

  // sequencer: accumulate, residual, square, norm add, report
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    norm_d     = norm_q;
    prev_d     = prev_q;
    ovf_d      = ovf_q;
    valid_d    = valid_q;
    rhs_d      = rhs_q;
    mend_d     = mend_q;
    res_d      = res_q;
    sq_d       = sq_q;
    status_d   = status_q;
    out_norm_d = out_norm_q;
    q_rd_o     = 1'b0;

    if (pop && valid_q) begin
      valid_d = 1'b0;
    end

    case (state_q)
      SAcc: begin
        if (!q_empty_i) begin
          q_rd_o = 1'b1;
          if (acc_sum[AccW] != acc_sum[AccW-1]) begin
            acc_d = acc_sum[AccW] ? AccMin : AccMax;
            ovf_d = 1'b1;
          end else begin
            acc_d = acc_sum[AccW-1:0];
          end
          if (q_item_i.close) begin
            rhs_d   = q_item_i.rhs;
            mend_d  = q_item_i.mend;
            state_d = SRes;
          end
        end
      end
      SRes: begin
        // round to q.12 and clamp to 24 bits
        if (resid_q12[AccW-11:ResW-1] != {(AccW-9-ResW){resid_q12[ResW-1]}}) begin
          res_d = resid_q12[AccW-11] ? ResMin : ResMax;
          ovf_d = 1'b1;
        end else begin
          res_d = resid_q12[ResW-1:0];
        end
        acc_d   = '0;
        state_d = SSq;
      end
      SSq: begin
        sq_d    = res_sq[SqW-1:0];
        state_d = SNorm;
      end
      SNorm: begin
        if (norm_sum[NormW]) begin
          norm_d = '1;
          ovf_d  = 1'b1;
        end else begin
          norm_d = norm_sum[NormW-1:0];
        end
        state_d = mend_q ? SFin : SAcc;
      end
      SFin: begin
        if (slot_free) begin
          if (ovf_q) begin
            status_d = StDiverged;
          end else if (norm_q <= tolerance_i) begin
            status_d = StConverged;
          end else if (norm_q < prev_q) begin
            status_d = StConverging;
          end else if (norm_q == prev_q) begin
            status_d = StIndeterminate;
          end else begin
            status_d = StDiverging;
          end
          out_norm_d = norm_q;
          valid_d    = 1'b1;
          prev_d     = norm_q;
          norm_d     = '0;
          ovf_d      = 1'b0;
          state_d    = SAcc;
        end
      end
      default: begin
        state_d = SAcc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SAcc;
      acc_q   <= '0;
      norm_q  <= '0;
      prev_q  <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      norm_q  <= norm_d;
      prev_q  <= prev_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rhs_q      <= rhs_d;
    mend_q     <= mend_d;
    res_q      <= res_d;
    sq_q       <= sq_d;
    status_q   <= status_d;
    out_norm_q <= out_norm_d;
  end

endmodule
`default_nettype wire

// File: src/residual_norm_convergence_monitor_top.sv
// the matrix-end beat passes the queue and the accumulate, residual, square, norm add and
//   report states, report waiting for a free output slot, before empty goes low; the back
//   part reads one element beat per cycle while the queue is not empty; a row close stalls
//   it in residual, square, norm add; the queue absorbs bursts of up to QUEUE_DEPTH beats
// reset: asynchronous, active low; clears accumulators, previous norm and tolerance
`default_nettype none
module residual_norm_convergence_monitor_top
  import rncm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [AddrW-1:0]       paddr,
  input  wire logic [DataW-1:0]       pwdata,
  output      logic [DataW-1:0]       prdata,
  output      logic                   pready,
  input  wire logic                   push,
  output      logic                   full,
  input  wire logic signed [ValW-1:0] matrix_value_i,
  input  wire logic signed [ValW-1:0] guess_value_i,
  input  wire logic signed [ValW-1:0] rhs_value_i,
  input  wire logic                   row_end_i,
  input  wire logic                   matrix_end_i,
  output      logic                   empty,
  input  wire logic                   pop,
  output      logic [StatusW-1:0]     status_o,
  output      logic [NormW-1:0]       norm_squared_o
);

  logic [NormW-1:0] tolerance_q;
  logic             q_wr, q_rd, q_full, q_empty;
  rncm_item_t       wr_item, rd_item;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == RegTolerance) ? DataW'(tolerance_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == RegTolerance) begin
      tolerance_q <= pwdata[NormW-1:0];
    end
  end

  // front: accept and classify beats
  rncm_front u_front (
    .push           (push),
    .full           (full),
    .matrix_value_i (matrix_value_i),
    .guess_value_i  (guess_value_i),
    .rhs_value_i    (rhs_value_i),
    .row_end_i      (row_end_i),
    .matrix_end_i   (matrix_end_i),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr),
    .q_item_o       (wr_item)
  );

  // element queue
  rncm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_item_o (rd_item),
    .empty_o   (q_empty)
  );

  // back: accumulate, close rows, report
  rncm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_item_i       (rd_item),
    .q_empty_i      (q_empty),
    .q_rd_o         (q_rd),
    .tolerance_i    (tolerance_q),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .norm_squared_o (norm_squared_o)
  );

endmodule
`default_nettype wire
